// File: sv/sa_pkg.sv
// shared types, constants and helpers for the steering agent block
// no dependencies; used by the top level, the checker and the testbench
package sa_pkg;

   // opcodes of an input word
   localparam logic [2:0] OP_SEEK    = 3'd0;
   localparam logic [2:0] OP_FLEE    = 3'd1;
   localparam logic [2:0] OP_EVADE   = 3'd2;
   localparam logic [2:0] OP_PURSUIT = 3'd3;
   localparam logic [2:0] OP_UPDATE  = 3'd4;
   localparam logic [2:0] OP_PLACE   = 3'd5;

   // register indexes of the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FORCE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERSE_MASS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WORLD_HEIGHT = 3'd4;
   localparam int CSR_DATA_W = 31;

   // reset values of the registers
   localparam logic [30:0] RST_MAX_SPEED    = 31'd65536;
   localparam logic [30:0] RST_MAX_FORCE    = 31'd65536;
   localparam logic [30:0] RST_INVERSE_MASS = 31'd65536;
   localparam logic [15:0] RST_WORLD_WIDTH  = 16'd800;
   localparam logic [15:0] RST_WORLD_HEIGHT = 16'd600;

   // fixed point one and the cap on a scaled magnitude
   localparam logic [31:0] FIX_ONE = 32'd65536;
   localparam logic [63:0] QUOT_CAP = 64'd1099511627776;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_vx;
      logic signed [31:0] target_vy;
      logic [30:0]        slowing_radius;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } rsp_word_type;

   // clamp to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -48'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // magnitude of a signed 32 bit value
   function automatic logic [31:0] mag32(input logic signed [31:0] a);
      logic [31:0] r;
      r = a[31] ? 32'(-a) : 32'(a);
      return r;
   endfunction

endpackage

// File: sv/sa_chan_if.sv
// valid/ready channel carrying one word per handshake
// depends on nothing; the word type is given at instantiation
interface sa_chan_if #(parameter type word_type = logic);
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/steering_agent_update.sv
// steering agent: one 2D agent in signed Q16.16 with a force accumulator
// depends on sa_pkg and sa_chan_if
//
// Usage:
//   req_chan takes one word per handshake: seek, flee, evade and pursuit add a
//   steering force, update integrates force, velocity and position with
//   limits and world wrap, place sets the position and clears the rest.
//   rsp_chan returns one word per request with position and velocity.
//   csr_we/csr_index/csr_wdata write the limits and world size; write only
//   while the block is idle.
// Throughput: one request at a time. The work is done by the bit-serial
//   divider (one quotient per vector component), the bit-serial square
//   root (one per vector length), both shared, and the inverse mass
//   scaling (product then shift, once per component).
// Reset: synchronous, clears the agent state and loads the register defaults.
// Stall: the finished word sits in the output register; the next request is
//   taken meanwhile and its result waits until that register is free.
module steering_agent_update (
   input  logic                             clock,
   input  logic                             reset,
   sa_chan_if.sink                          req_chan,
   sa_chan_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [sa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [38:0] {
      S_IDLE    = 39'b1 << 0,
      S_DISP    = 39'b1 << 1,
      S_PR_LEN  = 39'b1 << 2,
      S_PR_OY   = 39'b1 << 3,
      S_PR_WY   = 39'b1 << 4,
      S_PR_ADD  = 39'b1 << 5,
      S_ST_DIFF = 39'b1 << 6,
      S_ST_LEN  = 39'b1 << 7,
      S_ST_WX   = 39'b1 << 8,
      S_ST_WY   = 39'b1 << 9,
      S_ST_SLOW = 39'b1 << 10,
      S_SL_WX   = 39'b1 << 11,
      S_SL_WY   = 39'b1 << 12,
      S_ACC_D   = 39'b1 << 13,
      S_ACC_F   = 39'b1 << 14,
      S_UP_TF   = 39'b1 << 15,
      S_UP_TFX  = 39'b1 << 16,
      S_UP_TFY  = 39'b1 << 17,
      S_UP_IM   = 39'b1 << 18,
      S_UP_IMX  = 39'b1 << 19,
      S_UP_IMY  = 39'b1 << 20,
      S_UP_VEL  = 39'b1 << 21,
      S_UP_VL   = 39'b1 << 22,
      S_UP_TV   = 39'b1 << 23,
      S_UP_TVX  = 39'b1 << 24,
      S_UP_TVY  = 39'b1 << 25,
      S_UP_POS  = 39'b1 << 26,
      S_UP_WRAP = 39'b1 << 27,
      S_DONE    = 39'b1 << 28,
      S_LEN_X   = 39'b1 << 29,
      S_LEN_Y   = 39'b1 << 30,
      S_LEN_S   = 39'b1 << 31,
      S_LEN_W   = 39'b1 << 32,
      S_MD_MUL  = 39'b1 << 33,
      S_MD_DS   = 39'b1 << 34,
      S_MD_W    = 39'b1 << 35,
      S_MD_FIN  = 39'b1 << 36,
      S_SH_MUL  = 39'b1 << 37,
      S_SH_FIN  = 39'b1 << 38
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [2:0] op_ff, op_in;
   logic       away_ff, away_in;
   logic signed [31:0] tx_ff, tx_in, ty_ff, ty_in, tvx_ff, tvx_in, tvy_ff, tvy_in;
   logic [30:0] sr_ff, sr_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, vx_ff, vx_in, vy_ff, vy_in;
   logic signed [31:0] fx_ff, fx_in, fy_ff, fy_in, dx_ff, dx_in, dy_ff, dy_in;
   logic signed [41:0] wx_ff, wx_in, wy_ff, wy_in, q_ff, q_in;
   logic [31:0] len_ff, len_in;
   logic signed [31:0] lx_ff, lx_in, ly_ff, ly_in, md_a_ff, md_a_in;
   logic [31:0] md_m_ff, md_m_in, md_d_ff, md_d_in;
   logic [63:0] mul_ff, mul_in, sum_ff, sum_in;
   logic [63:0] sq_n_ff, sq_n_in;
   logic [34:0] sq_rem_ff, sq_rem_in;
   logic [31:0] sq_root_ff, sq_root_in;
   logic [63:0] dv_num_ff, dv_num_in, dv_q_ff, dv_q_in;
   logic [31:0] dv_rem_ff, dv_rem_in;
   logic [30:0] ms_ff, ms_in, mf_ff, mf_in, im_ff, im_in;
   logic [15:0] ww_ff, ww_in, wh_ff, wh_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sa_pkg::rsp_word_type rsp_data_ff, rsp_data_in;

   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [36:0] sq_sh, sq_trial;
   logic [34:0] sq_rem_nx;
   logic [31:0] sq_root_nx;
   logic [32:0] dv_sh;
   logic [31:0] dv_rem_nx;
   logic [63:0] dv_q_nx;
   logic [40:0] q_mag;
   logic [40:0] sh_mag;
   logic signed [31:0] dif_x, dif_y;

   // wrap one coordinate at the world edge
   function automatic logic signed [31:0] wrap(input logic signed [31:0] p,
                                               input logic [15:0] size);
      logic signed [47:0] edge_v;
      logic signed [47:0] r;
      edge_v = 48'({size, 16'b0});
      r = 48'(p);
      if (r < 48'sd0) begin
         r = 48'(sa_pkg::sat32(edge_v));
      end
      if (r > edge_v) begin
         r = 48'sd0;
      end
      return r[31:0];
   endfunction

   // shared multiplier operands
   always_comb begin
      mul_a = sa_pkg::mag32(md_a_ff);
      mul_b = md_m_ff;
      if (state_ff == S_LEN_X) begin
         mul_a = sa_pkg::mag32(lx_ff);
         mul_b = sa_pkg::mag32(lx_ff);
      end else if (state_ff == S_LEN_Y) begin
         mul_a = sa_pkg::mag32(ly_ff);
         mul_b = sa_pkg::mag32(ly_ff);
      end
      mul_p = {32'b0, mul_a} * {32'b0, mul_b};
   end

   // one square root step: two radicand bits per cycle
   always_comb begin
      sq_sh    = {sq_rem_ff, sq_n_ff[63:62]};
      sq_trial = {3'b0, sq_root_ff, 2'b01};
      if (sq_sh >= sq_trial) begin
         sq_rem_nx  = 35'(sq_sh - sq_trial);
         sq_root_nx = {sq_root_ff[30:0], 1'b1};
      end else begin
         sq_rem_nx  = sq_sh[34:0];
         sq_root_nx = {sq_root_ff[30:0], 1'b0};
      end
   end

   // one divider step: one quotient bit per cycle
   always_comb begin
      dv_sh = {dv_rem_ff, dv_num_ff[63]};
      if (dv_sh >= {1'b0, md_d_ff}) begin
         dv_rem_nx = 32'(dv_sh - {1'b0, md_d_ff});
         dv_q_nx   = {dv_q_ff[62:0], 1'b1};
      end else begin
         dv_rem_nx = dv_sh[31:0];
         dv_q_nx   = {dv_q_ff[62:0], 1'b0};
      end
      q_mag = (dv_q_ff > sa_pkg::QUOT_CAP) ? 41'(sa_pkg::QUOT_CAP) : dv_q_ff[40:0];
   end

   // Q16.16 product magnitude: drop the fraction bits, then cap
   always_comb begin
      sh_mag = (mul_ff[63:16] > 48'(sa_pkg::QUOT_CAP)) ? 41'(sa_pkg::QUOT_CAP)
                                                       : mul_ff[56:16];
   end

   // distance from the agent to the current target
   assign dif_x = sa_pkg::sat32(48'(tx_ff) - 48'(px_ff));
   assign dif_y = sa_pkg::sat32(48'(ty_ff) - 48'(py_ff));

   // sequencer and datapath next state
   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  cnt_in = cnt_ff;
      op_in = op_ff;  away_in = away_ff;
      tx_in = tx_ff;  ty_in = ty_ff;  tvx_in = tvx_ff;  tvy_in = tvy_ff;  sr_in = sr_ff;
      px_in = px_ff;  py_in = py_ff;  vx_in = vx_ff;  vy_in = vy_ff;
      fx_in = fx_ff;  fy_in = fy_ff;  dx_in = dx_ff;  dy_in = dy_ff;
      wx_in = wx_ff;  wy_in = wy_ff;  q_in = q_ff;  len_in = len_ff;
      lx_in = lx_ff;  ly_in = ly_ff;
      md_a_in = md_a_ff;  md_m_in = md_m_ff;  md_d_in = md_d_ff;
      mul_in = mul_p;  sum_in = sum_ff;
      sq_n_in = sq_n_ff;  sq_rem_in = sq_rem_ff;  sq_root_in = sq_root_ff;
      dv_num_in = dv_num_ff;  dv_rem_in = dv_rem_ff;  dv_q_in = dv_q_ff;
      ms_in = ms_ff;  mf_in = mf_ff;  im_in = im_ff;  ww_in = ww_ff;  wh_in = wh_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            sa_pkg::CSR_MAX_SPEED:    ms_in = csr_wdata;
            sa_pkg::CSR_MAX_FORCE:    mf_in = csr_wdata;
            sa_pkg::CSR_INVERSE_MASS: im_in = csr_wdata;
            sa_pkg::CSR_WORLD_WIDTH:  ww_in = csr_wdata[15:0];
            sa_pkg::CSR_WORLD_HEIGHT: wh_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in  = req_chan.data.opcode;
               tx_in  = req_chan.data.target_x;
               ty_in  = req_chan.data.target_y;
               tvx_in = req_chan.data.target_vx;
               tvy_in = req_chan.data.target_vy;
               sr_in  = req_chan.data.slowing_radius;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (op_ff)
               sa_pkg::OP_SEEK: begin
                  away_in = 1'b0;  state_in = S_ST_DIFF;
               end
               sa_pkg::OP_FLEE: begin
                  away_in = 1'b1;  sr_in = '0;  state_in = S_ST_DIFF;
               end
               sa_pkg::OP_EVADE, sa_pkg::OP_PURSUIT: begin
                  away_in = (op_ff == sa_pkg::OP_EVADE);
                  if (op_ff == sa_pkg::OP_EVADE) begin
                     sr_in = '0;
                  end
                  lx_in = dif_x;  ly_in = dif_y;
                  ret_in = S_PR_LEN;  state_in = S_LEN_X;
               end
               sa_pkg::OP_UPDATE: begin
                  lx_in = fx_ff;  ly_in = fy_ff;
                  ret_in = S_UP_TF;  state_in = S_LEN_X;
               end
               sa_pkg::OP_PLACE: begin
                  px_in = tx_ff;  py_in = ty_ff;
                  vx_in = '0;  vy_in = '0;  fx_in = '0;  fy_in = '0;
                  state_in = S_DONE;
               end
               default: state_in = S_DONE;
            endcase
         end
         // predicted target position
         S_PR_LEN: begin
            if (ms_ff == '0) begin
               wx_in = '0;  wy_in = '0;  state_in = S_PR_ADD;
            end else begin
               md_a_in = tvx_ff;  md_m_in = len_ff;  md_d_in = {1'b0, ms_ff};
               ret_in = S_PR_OY;  state_in = S_MD_MUL;
            end
         end
         S_PR_OY: begin
            wx_in = q_ff;
            md_a_in = tvy_ff;  md_m_in = len_ff;  md_d_in = {1'b0, ms_ff};
            ret_in = S_PR_WY;  state_in = S_MD_MUL;
         end
         S_PR_WY: begin
            wy_in = q_ff;  state_in = S_PR_ADD;
         end
         S_PR_ADD: begin
            tx_in = sa_pkg::sat32(48'(tx_ff) + 48'(wx_ff));
            ty_in = sa_pkg::sat32(48'(ty_ff) + 48'(wy_ff));
            state_in = S_ST_DIFF;
         end
         // desired velocity toward or away from the target
         S_ST_DIFF: begin
            dx_in = dif_x;  dy_in = dif_y;
            lx_in = dif_x;  ly_in = dif_y;
            ret_in = S_ST_LEN;  state_in = S_LEN_X;
         end
         S_ST_LEN: begin
            if (len_ff == '0) begin
               wx_in = '0;  wy_in = '0;  state_in = S_ST_SLOW;
            end else begin
               md_a_in = dx_ff;  md_m_in = {1'b0, ms_ff};  md_d_in = len_ff;
               ret_in = S_ST_WX;  state_in = S_MD_MUL;
            end
         end
         S_ST_WX: begin
            wx_in = q_ff;
            md_a_in = dy_ff;  md_m_in = {1'b0, ms_ff};  md_d_in = len_ff;
            ret_in = S_ST_WY;  state_in = S_MD_MUL;
         end
         S_ST_WY: begin
            wy_in = q_ff;  state_in = S_ST_SLOW;
         end
         S_ST_SLOW: begin
            if (away_ff) begin
               wx_in = -wx_ff;  wy_in = -wy_ff;  state_in = S_ACC_D;
            end else if (sr_ff != '0 && len_ff <= {1'b0, sr_ff}) begin
               md_a_in = 32'(wx_ff);  md_m_in = len_ff;  md_d_in = {1'b0, sr_ff};
               ret_in = S_SL_WX;  state_in = S_MD_MUL;
            end else begin
               state_in = S_ACC_D;
            end
         end
         S_SL_WX: begin
            wx_in = q_ff;
            md_a_in = 32'(wy_ff);  md_m_in = len_ff;  md_d_in = {1'b0, sr_ff};
            ret_in = S_SL_WY;  state_in = S_MD_MUL;
         end
         S_SL_WY: begin
            wy_in = q_ff;  state_in = S_ACC_D;
         end
         // steering force into the accumulator
         S_ACC_D: begin
            wx_in = 42'(sa_pkg::sat32(48'(wx_ff) - 48'(vx_ff)));
            wy_in = 42'(sa_pkg::sat32(48'(wy_ff) - 48'(vy_ff)));
            state_in = S_ACC_F;
         end
         S_ACC_F: begin
            fx_in = sa_pkg::sat32(48'(fx_ff) + 48'(wx_ff));
            fy_in = sa_pkg::sat32(48'(fy_ff) + 48'(wy_ff));
            state_in = S_DONE;
         end
         // update: limit force
         S_UP_TF: begin
            if (len_ff > {1'b0, mf_ff}) begin
               md_a_in = fx_ff;  md_m_in = {1'b0, mf_ff};  md_d_in = len_ff;
               ret_in = S_UP_TFX;  state_in = S_MD_MUL;
            end else begin
               state_in = S_UP_IM;
            end
         end
         S_UP_TFX: begin
            fx_in = 32'(q_ff);
            md_a_in = fy_ff;  md_m_in = {1'b0, mf_ff};  md_d_in = len_ff;
            ret_in = S_UP_TFY;  state_in = S_MD_MUL;
         end
         S_UP_TFY: begin
            fy_in = 32'(q_ff);  state_in = S_UP_IM;
         end
         // scale force by inverse mass
         S_UP_IM: begin
            md_a_in = fx_ff;  md_m_in = {1'b0, im_ff};
            ret_in = S_UP_IMX;  state_in = S_SH_MUL;
         end
         S_UP_IMX: begin
            fx_in = sa_pkg::sat32(48'(q_ff));
            md_a_in = fy_ff;  md_m_in = {1'b0, im_ff};
            ret_in = S_UP_IMY;  state_in = S_SH_MUL;
         end
         S_UP_IMY: begin
            fy_in = sa_pkg::sat32(48'(q_ff));  state_in = S_UP_VEL;
         end
         // integrate velocity and limit speed
         S_UP_VEL: begin
            vx_in = sa_pkg::sat32(48'(vx_ff) + 48'(fx_ff));
            vy_in = sa_pkg::sat32(48'(vy_ff) + 48'(fy_ff));
            state_in = S_UP_VL;
         end
         S_UP_VL: begin
            lx_in = vx_ff;  ly_in = vy_ff;
            ret_in = S_UP_TV;  state_in = S_LEN_X;
         end
         S_UP_TV: begin
            if (len_ff > {1'b0, ms_ff}) begin
               md_a_in = vx_ff;  md_m_in = {1'b0, ms_ff};  md_d_in = len_ff;
               ret_in = S_UP_TVX;  state_in = S_MD_MUL;
            end else begin
               state_in = S_UP_POS;
            end
         end
         S_UP_TVX: begin
            vx_in = 32'(q_ff);
            md_a_in = vy_ff;  md_m_in = {1'b0, ms_ff};  md_d_in = len_ff;
            ret_in = S_UP_TVY;  state_in = S_MD_MUL;
         end
         S_UP_TVY: begin
            vy_in = 32'(q_ff);  state_in = S_UP_POS;
         end
         // move and wrap
         S_UP_POS: begin
            px_in = sa_pkg::sat32(48'(px_ff) + 48'(vx_ff));
            py_in = sa_pkg::sat32(48'(py_ff) + 48'(vy_ff));
            state_in = S_UP_WRAP;
         end
         S_UP_WRAP: begin
            px_in = wrap(px_ff, ww_ff);
            py_in = wrap(py_ff, wh_ff);
            state_in = S_DONE;
         end
         // hand the word to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.pos_x = px_ff;
               rsp_data_in.pos_y = py_ff;
               rsp_data_in.vel_x = vx_ff;
               rsp_data_in.vel_y = vy_ff;
               state_in = S_IDLE;
            end
         end
         // vector length: two squares then the root
         S_LEN_X: state_in = S_LEN_Y;
         S_LEN_Y: begin
            sum_in = mul_ff;  state_in = S_LEN_S;
         end
         S_LEN_S: begin
            sq_n_in = sum_ff + mul_ff;
            sq_rem_in = '0;  sq_root_in = '0;  cnt_in = 6'd31;
            state_in = S_LEN_W;
         end
         S_LEN_W: begin
            sq_n_in = {sq_n_ff[61:0], 2'b00};
            sq_rem_in = sq_rem_nx;  sq_root_in = sq_root_nx;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               len_in = sq_root_nx;  state_in = ret_ff;
            end
         end
         // scaled magnitude: product then long division
         S_MD_MUL: state_in = S_MD_DS;
         S_MD_DS: begin
            dv_num_in = mul_ff;  dv_rem_in = '0;  dv_q_in = '0;  cnt_in = 6'd63;
            state_in = S_MD_W;
         end
         S_MD_W: begin
            dv_num_in = {dv_num_ff[62:0], 1'b0};
            dv_rem_in = dv_rem_nx;  dv_q_in = dv_q_nx;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == '0) begin
               state_in = S_MD_FIN;
            end
         end
         S_MD_FIN: begin
            q_in = md_a_ff[31] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
            state_in = ret_ff;
         end
         // Q16.16 product: multiply then shift
         S_SH_MUL: state_in = S_SH_FIN;
         S_SH_FIN: begin
            q_in = md_a_ff[31] ? -$signed({1'b0, sh_mag}) : $signed({1'b0, sh_mag});
            state_in = ret_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and agent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         px_ff <= '0;  py_ff <= '0;  vx_ff <= '0;  vy_ff <= '0;
         fx_ff <= '0;  fy_ff <= '0;
         ms_ff <= sa_pkg::RST_MAX_SPEED;
         mf_ff <= sa_pkg::RST_MAX_FORCE;
         im_ff <= sa_pkg::RST_INVERSE_MASS;
         ww_ff <= sa_pkg::RST_WORLD_WIDTH;
         wh_ff <= sa_pkg::RST_WORLD_HEIGHT;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         px_ff <= px_in;  py_ff <= py_in;  vx_ff <= vx_in;  vy_ff <= vy_in;
         fx_ff <= fx_in;  fy_ff <= fy_in;
         ms_ff <= ms_in;  mf_ff <= mf_in;  im_ff <= im_in;
         ww_ff <= ww_in;  wh_ff <= wh_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      ret_ff <= ret_in;  cnt_ff <= cnt_in;  op_ff <= op_in;  away_ff <= away_in;
      tx_ff <= tx_in;  ty_ff <= ty_in;  tvx_ff <= tvx_in;  tvy_ff <= tvy_in;
      sr_ff <= sr_in;  dx_ff <= dx_in;  dy_ff <= dy_in;
      wx_ff <= wx_in;  wy_ff <= wy_in;  q_ff <= q_in;  len_ff <= len_in;
      lx_ff <= lx_in;  ly_ff <= ly_in;
      md_a_ff <= md_a_in;  md_m_ff <= md_m_in;  md_d_ff <= md_d_in;
      mul_ff <= mul_in;  sum_ff <= sum_in;
      sq_n_ff <= sq_n_in;  sq_rem_ff <= sq_rem_in;  sq_root_ff <= sq_root_in;
      dv_num_ff <= dv_num_in;  dv_rem_ff <= dv_rem_in;  dv_q_ff <= dv_q_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

// File: sv/sa_checker.sv
// port-level checks for the steering agent block, bound to the top level
// depends on sa_pkg and steering_agent_update
module sa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sa_pkg::rsp_word_type rsp_data
);

   // a held result word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word dropped or changed while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one request at a time
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // a new result appears only at the end of a request's work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without work in progress");

endmodule

bind steering_agent_update sa_checker u_sa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

// File: tb/steering_agent_update_test.sv
// self-checking test of the steering agent block: directed words, register sweeps, random
// traffic with idling and a long output stall; depends on sa_pkg, sa_chan_if, steering_agent_update
module steering_agent_update_test;

   logic clock;
   logic reset;
   logic csr_we;
   logic [sa_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sa_pkg::CSR_DATA_W-1:0] csr_wdata;

   sa_chan_if #(.word_type(sa_pkg::req_word_type)) req_if ();
   sa_chan_if #(.word_type(sa_pkg::rsp_word_type)) rsp_if ();

   steering_agent_update DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_if.sink), .rsp_chan(rsp_if.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // agent state and limits as the block should hold them
   longint agent_pos_x, agent_pos_y, agent_vel_x, agent_vel_y, agent_frc_x, agent_frc_y;
   longint unsigned lim_speed, lim_force, inv_mass, world_w, world_h;

   sa_pkg::rsp_word_type pending_rsp_q[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial begin
      #(64'd80_000_000);
      $display("steering_agent_update verification failed");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // ---------------- predictor ----------------
   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned absval(input longint a);
      return (a < 0) ? longint'(-a) : a;
   endfunction

   // a * m / d toward zero, magnitude capped at 2^40
   function automatic longint scale_by(input longint a, input longint unsigned m,
                                        input longint unsigned d);
      longint unsigned q;
      q = absval(a) * m / d;
      if (q > sa_pkg::QUOT_CAP) q = sa_pkg::QUOT_CAP;
      return (a < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint unsigned root64(input longint unsigned n);
      longint unsigned r, probe;
      r = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= r + probe) begin
            n = n - (r + probe);
            r = (r >> 1) + probe;
         end else begin
            r = r >> 1;
         end
         probe = probe >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned vec_len(input longint x, input longint y);
      longint unsigned a, b;
      a = absval(x);
      b = absval(y);
      return root64(a * a + b * b);
   endfunction

   task automatic limit_vec(inout longint x, inout longint y, input longint unsigned lim);
      longint unsigned l;
      l = vec_len(x, y);
      if (l > lim) begin
         x = scale_by(x, lim, l);
         y = scale_by(y, lim, l);
      end
   endtask

   task automatic steer_toward(input longint tx, input longint ty,
                               input longint unsigned radius, input bit away);
      longint dx, dy, wx, wy;
      longint unsigned l;
      dx = clamp32(tx - agent_pos_x);
      dy = clamp32(ty - agent_pos_y);
      l = vec_len(dx, dy);
      wx = 0;
      wy = 0;
      if (l != 0) begin
         wx = scale_by(dx, lim_speed, l);
         wy = scale_by(dy, lim_speed, l);
      end
      if (away) begin
         wx = -wx;
         wy = -wy;
      end else if (radius != 0 && l <= radius) begin
         // arrival slowing inside the radius
         wx = scale_by(wx, l, radius);
         wy = scale_by(wy, l, radius);
      end
      agent_frc_x = clamp32(agent_frc_x + clamp32(wx - agent_vel_x));
      agent_frc_y = clamp32(agent_frc_y + clamp32(wy - agent_vel_y));
   endtask

   // target position extrapolated by distance / max speed
   task automatic aim_ahead(input longint tx, input longint ty, input longint vx,
                            input longint vy, output longint fx, output longint fy);
      longint dx, dy, ox, oy;
      longint unsigned l;
      dx = clamp32(tx - agent_pos_x);
      dy = clamp32(ty - agent_pos_y);
      l = vec_len(dx, dy);
      ox = 0;
      oy = 0;
      if (lim_speed != 0) begin
         ox = scale_by(vx, l, lim_speed);
         oy = scale_by(vy, l, lim_speed);
      end
      fx = clamp32(tx + ox);
      fy = clamp32(ty + oy);
   endtask

   function automatic longint wrap_axis(input longint p, input longint unsigned size);
      longint rim;
      rim = longint'(size << 16);
      if (p < 0) p = clamp32(rim);
      if (p > rim) p = 0;
      return p;
   endfunction

   task automatic apply_word(input sa_pkg::req_word_type w, output sa_pkg::rsp_word_type r);
      longint tx, ty, tvx, tvy, fx, fy;
      longint unsigned radius;
      tx = longint'(w.target_x);
      ty = longint'(w.target_y);
      tvx = longint'(w.target_vx);
      tvy = longint'(w.target_vy);
      radius = longint'(w.slowing_radius);
      case (w.opcode)
         sa_pkg::OP_SEEK: steer_toward(tx, ty, radius, 1'b0);
         sa_pkg::OP_FLEE: steer_toward(tx, ty, 0, 1'b1);
         sa_pkg::OP_EVADE: begin
            aim_ahead(tx, ty, tvx, tvy, fx, fy);
            steer_toward(fx, fy, 0, 1'b1);
         end
         sa_pkg::OP_PURSUIT: begin
            aim_ahead(tx, ty, tvx, tvy, fx, fy);
            steer_toward(fx, fy, radius, 1'b0);
         end
         sa_pkg::OP_UPDATE: begin
            limit_vec(agent_frc_x, agent_frc_y, lim_force);
            agent_frc_x = clamp32(scale_by(agent_frc_x, inv_mass, sa_pkg::FIX_ONE));
            agent_frc_y = clamp32(scale_by(agent_frc_y, inv_mass, sa_pkg::FIX_ONE));
            agent_vel_x = clamp32(agent_vel_x + agent_frc_x);
            agent_vel_y = clamp32(agent_vel_y + agent_frc_y);
            limit_vec(agent_vel_x, agent_vel_y, lim_speed);
            agent_pos_x = wrap_axis(clamp32(agent_pos_x + agent_vel_x), world_w);
            agent_pos_y = wrap_axis(clamp32(agent_pos_y + agent_vel_y), world_h);
         end
         sa_pkg::OP_PLACE: begin
            agent_pos_x = tx;
            agent_pos_y = ty;
            agent_vel_x = 0;
            agent_vel_y = 0;
            agent_frc_x = 0;
            agent_frc_y = 0;
         end
         default: ;
      endcase
      r.pos_x = agent_pos_x[31:0];
      r.pos_y = agent_pos_y[31:0];
      r.vel_x = agent_vel_x[31:0];
      r.vel_y = agent_vel_y[31:0];
   endtask

   // ---------------- drivers ----------------
   // send one word; valid stays high between back-to-back words
   task automatic send_word(input sa_pkg::req_word_type w);
      sa_pkg::rsp_word_type r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= w;
      do @(posedge clock); while (!req_if.ready);
      apply_word(w, r);
      pending_rsp_q.push_back(r);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(input logic [sa_pkg::CSR_IDX_W-1:0] idx,
                            input longint unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[30:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         sa_pkg::CSR_MAX_SPEED: lim_speed = val & 64'h7FFFFFFF;
         sa_pkg::CSR_MAX_FORCE: lim_force = val & 64'h7FFFFFFF;
         sa_pkg::CSR_INVERSE_MASS: inv_mass = val & 64'h7FFFFFFF;
         sa_pkg::CSR_WORLD_WIDTH: world_w = val & 64'hFFFF;
         sa_pkg::CSR_WORLD_HEIGHT: world_h = val & 64'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_limits(input longint unsigned spd, input longint unsigned frc,
                             input longint unsigned im, input longint unsigned ww,
                             input longint unsigned wh);
      write_csr(sa_pkg::CSR_MAX_SPEED, spd);
      write_csr(sa_pkg::CSR_MAX_FORCE, frc);
      write_csr(sa_pkg::CSR_INVERSE_MASS, im);
      write_csr(sa_pkg::CSR_WORLD_WIDTH, ww);
      write_csr(sa_pkg::CSR_WORLD_HEIGHT, wh);
   endtask

   function automatic sa_pkg::req_word_type make_word(input logic [2:0] op, input longint x,
                                              input longint y, input longint vx,
                                              input longint vy, input longint unsigned sr);
      sa_pkg::req_word_type w;
      w.opcode = op;
      w.target_x = x[31:0];
      w.target_y = y[31:0];
      w.target_vx = vx[31:0];
      w.target_vy = vy[31:0];
      w.slowing_radius = sr[30:0];
      return w;
   endfunction

   function automatic logic [31:0] rand_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return $urandom_range(0, 900 << 16);
      if (pick < 80) return 32'($signed($urandom_range(0, 2 << 20)) - (1 << 20));
      return $urandom;
   endfunction

   function automatic logic [31:0] rand_vel();
      if ($urandom_range(3) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
   endfunction

   function automatic sa_pkg::req_word_type rand_word();
      sa_pkg::req_word_type w;
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) w.opcode = 3'($urandom_range(0, 3));
      else if (pick < 88) w.opcode = sa_pkg::OP_UPDATE;
      else if (pick < 97) w.opcode = sa_pkg::OP_PLACE;
      else w.opcode = 3'($urandom_range(6, 7));
      w.target_x = rand_coord();
      w.target_y = rand_coord();
      w.target_vx = rand_vel();
      w.target_vy = rand_vel();
      pick = $urandom_range(99);
      if (pick < 30) w.slowing_radius = '0;
      else if (pick < 75) w.slowing_radius = 31'($urandom_range(0, 300 << 16));
      else w.slowing_radius = 31'($urandom);
      return w;
   endfunction

   // ---------------- response side ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      sa_pkg::rsp_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_if.data.pos_x !== want.pos_x)
               report_mismatch($sformatf("pos_x %h want %h", rsp_if.data.pos_x, want.pos_x));
            if (rsp_if.data.pos_y !== want.pos_y)
               report_mismatch($sformatf("pos_y %h want %h", rsp_if.data.pos_y, want.pos_y));
            if (rsp_if.data.vel_x !== want.vel_x)
               report_mismatch($sformatf("vel_x %h want %h", rsp_if.data.vel_x, want.vel_x));
            if (rsp_if.data.vel_y !== want.vel_y)
               report_mismatch($sformatf("vel_y %h want %h", rsp_if.data.vel_y, want.vel_y));
         end
      end
   end

   // ---------------- tests ----------------
   task automatic test_directed();
      longint one;
      one = 65536;
      send_word(make_word(sa_pkg::OP_SEEK, 0, 0, 0, 0, 0));                 // zero distance
      send_word(make_word(sa_pkg::OP_SEEK, 100 * one, 50 * one, 0, 0, 0));  // no slowing
      send_word(make_word(sa_pkg::OP_SEEK, 3 * one, 4 * one, 0, 0, 10 * one));  // slowing
      send_word(make_word(sa_pkg::OP_UPDATE, 0, 0, 0, 0, 0));
      send_word(make_word(sa_pkg::OP_FLEE, -5 * one, 7 * one, 0, 0, 99 * one));
      send_word(make_word(sa_pkg::OP_PURSUIT, 40 * one, 20 * one, one, -one, 50 * one));
      send_word(make_word(sa_pkg::OP_EVADE, 10 * one, 10 * one, -2 * one, 3 * one, 0));
      send_word(make_word(sa_pkg::OP_UPDATE, 0, 0, 0, 0, 0));
      send_word(make_word(sa_pkg::OP_UPDATE, 0, 0, 0, 0, 0));              // force kept
      send_word(make_word(3'd6, 1, 2, 3, 4, 5));
      send_word(make_word(3'd7, -1, -2, -3, -4, 64'h7FFFFFFF));
      // extremes, huge prediction and saturating distance
      send_word(make_word(sa_pkg::OP_PLACE, -64'sd2147483648, 64'sd2147483647, 0, 0, 0));
      send_word(make_word(sa_pkg::OP_PURSUIT, 64'sd2147483647, -64'sd2147483648,
                          64'sd2147483647, -64'sd2147483648, 64'h7FFFFFFF));
      send_word(make_word(sa_pkg::OP_EVADE, 64'sd2147483647, -64'sd2147483648,
                          -64'sd2147483648, 64'sd2147483647, 0));
      send_word(make_word(sa_pkg::OP_SEEK, 64'sd2147483647, -64'sd2147483648, 0, 0,
                          64'h7FFFFFFF));
      send_word(make_word(sa_pkg::OP_UPDATE, 0, 0, 0, 0, 0));               // wrap below zero
      send_word(make_word(sa_pkg::OP_PLACE, 900 * one, 700 * one, 0, 0, 0));
      send_word(make_word(sa_pkg::OP_SEEK, 1000 * one, 800 * one, 0, 0, 0));
      send_word(make_word(sa_pkg::OP_UPDATE, 0, 0, 0, 0, 0));               // wrap above edge
      send_word(make_word(sa_pkg::OP_PLACE, 0, 0, 0, 0, 0));
      drain();
   endtask

   // register extremes with a short well-formed sequence each
   task automatic test_limit_sweep();
      longint unsigned top;
      top = 64'h7FFFFFFF;
      set_limits(0, 0, 0, 1, 1);
      repeat (2) begin
         send_word(make_word(sa_pkg::OP_PURSUIT, 5 << 16, 6 << 16, 1 << 16, 1 << 16, 1 << 20));
         send_word(make_word(sa_pkg::OP_UPDATE, 0, 0, 0, 0, 0));
      end
      drain();
      set_limits(top, top, top, 65535, 65535);
      send_word(make_word(sa_pkg::OP_PLACE, 64'sd2147483000, 64'sd2147483000, 0, 0, 0));
      send_word(make_word(sa_pkg::OP_SEEK, -64'sd2147483648, -64'sd2147483648, 0, 0, 0));
      send_word(make_word(sa_pkg::OP_EVADE, 0, 0, 64'sd2147483647, 64'sd2147483647, 0));
      send_word(make_word(sa_pkg::OP_UPDATE, 0, 0, 0, 0, 0));
      send_word(make_word(sa_pkg::OP_UPDATE, 0, 0, 0, 0, 0));
      drain();
      set_limits(3 << 16, 1 << 15, 2 << 16, 200, 150);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_word(rand_word());
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 24;
      recv_idle_pct = 51;
      run_random(500);
      drain();
      set_limits($urandom_range(1 << 14, 8 << 16), $urandom_range(1 << 12, 4 << 16),
                 $urandom_range(1 << 14, 4 << 16), $urandom_range(50, 2000),
                 $urandom_range(50, 2000));
      send_idle_pct = 51;
      recv_idle_pct = 24;
      run_random(500);
      drain();
      set_limits(sa_pkg::RST_MAX_SPEED, sa_pkg::RST_MAX_FORCE, sa_pkg::RST_INVERSE_MASS,
                 sa_pkg::RST_WORLD_WIDTH, sa_pkg::RST_WORLD_HEIGHT);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(450);
      drain();
   endtask

   // receiver holds off while words keep coming, so the input stalls
   task automatic test_output_stall();
      hold_left = 3000;
      run_random(8);
      drain();
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      lim_speed = sa_pkg::RST_MAX_SPEED;
      lim_force = sa_pkg::RST_MAX_FORCE;
      inv_mass = sa_pkg::RST_INVERSE_MASS;
      world_w = sa_pkg::RST_WORLD_WIDTH;
      world_h = sa_pkg::RST_WORLD_HEIGHT;
      agent_pos_x = 0;
      agent_pos_y = 0;
      agent_vel_x = 0;
      agent_vel_y = 0;
      agent_frc_x = 0;
      agent_frc_y = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_limit_sweep();
      test_output_stall();
      test_random_traffic();

      if (error_count == 0) begin
         $display("steering_agent_update verification clean");
      end else begin
         $display("steering_agent_update verification failed");
      end
      $finish;
   end
endmodule

// File: steering_agent_update.f
sv/sa_pkg.sv
sv/sa_chan_if.sv
sv/steering_agent_update.sv
sv/sa_checker.sv
tb/steering_agent_update_test.sv
